/* design/ccc_pkg.sv */
// Shared constants, types and the sequencer state type for the circular cross-correlation block.
package ccc_pkg;

   // Register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int VL_BITS = 7;
   localparam logic [VL_BITS-1:0] VL_RESET = 7'd40;
   localparam logic [0:0] REG_VECTOR_LENGTH = 1'b0;
   localparam int MIN_LENGTH = 2;

   // Result fields
   localparam int LAG_BITS = 6;
   localparam int CORR_BITS = 38;

   // Defaults for the top-level parameters
   localparam int DEF_MAX_LENGTH = 64;
   localparam int DEF_SAMPLE_BITS = 16;

   // Final count of the drain counter, which counts up from zero to this value while the
   // multiply-accumulate pipeline empties after the last term.
   localparam logic [1:0] DRAIN_END = 2'd2;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_RUN,
      ST_DRAIN
   } seq_state_type;

   // Control that travels with each product term through the datapath.
   typedef struct packed {
      logic                vld;
      logic                first;
      logic                last;
      logic [LAG_BITS-1:0] lag;
      logic                last_lag;
   } term_tag_type;

endpackage

/* design/ccc_sample_ram.sv */
// Single-port-write, single-port-read sample memory with a registered read.
module ccc_sample_ram #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/ccc_csr.sv */
// APB-style register file holding the vector length and its saturated effective value.
module ccc_csr
   import ccc_pkg::*;
#(
   parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready,
   output logic [$clog2(MAX_LENGTH+1)-1:0] len
);

   localparam int CNT_BITS = $clog2(MAX_LENGTH + 1);
   localparam int CMP_BITS = (CNT_BITS > VL_BITS) ? CNT_BITS : VL_BITS;

   logic [VL_BITS-1:0]  vl_ff;
   logic [VL_BITS-1:0]  vl_in;
   logic                sel_vl;
   logic [CMP_BITS-1:0] vl_wide;

   assign sel_vl = (paddr[CSR_ADDR_BITS-1:2] == REG_VECTOR_LENGTH);
   assign pready = 1'b1;

   always_comb begin
      vl_in = vl_ff;
      if (psel && penable && pwrite && sel_vl) begin
         vl_in = pwdata[VL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vl_ff <= VL_RESET;
      end else begin
         vl_ff <= vl_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (sel_vl) begin
         prdata = CSR_DATA_BITS'(vl_ff);
      end
   end

   // The length actually used is clamped to the legal range.
   assign vl_wide = CMP_BITS'(vl_ff);

   always_comb begin
      priority if (vl_wide < CMP_BITS'(MIN_LENGTH)) begin
         len = CNT_BITS'(MIN_LENGTH);
      end else if (vl_wide > CMP_BITS'(MAX_LENGTH)) begin
         len = CNT_BITS'(MAX_LENGTH);
      end else begin
         len = vl_wide[CNT_BITS-1:0];
      end
   end

endmodule

/* design/ccc_mac.sv */
// Multiply-accumulate pipeline that turns memory read pairs into one correlation per lag.
module ccc_mac
   import ccc_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  term_tag_type           tag_in,
   input  logic [SAMPLE_BITS-1:0] a_data,
   input  logic [SAMPLE_BITS-1:0] b_data,
   output logic                   rsp_valid,
   output logic [LAG_BITS-1:0]    rsp_lag,
   output logic [CORR_BITS-1:0]   rsp_correlation,
   output logic                   rsp_last_lag
);

   localparam int PROD_BITS = 2 * SAMPLE_BITS;
   localparam int EXT_BITS = (PROD_BITS > CORR_BITS) ? PROD_BITS : CORR_BITS;

   term_tag_type                tag1_ff;
   term_tag_type                tag2_ff;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [EXT_BITS-1:0]  prod_ext;
   logic [CORR_BITS-1:0]        term;
   logic [CORR_BITS-1:0]        acc_ff;
   logic [CORR_BITS-1:0]        acc_in;
   logic                        rsp_valid_ff;
   logic [LAG_BITS-1:0]         lag_ff;
   logic [CORR_BITS-1:0]        corr_ff;
   logic                        last_lag_ff;

   // The tag passes through tag1_ff and tag2_ff to line up with the registered memory data and product.
   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff.vld <= 1'b0;
         tag2_ff.vld <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tag1_ff.vld <= tag_in.vld;
         tag2_ff.vld <= tag1_ff.vld;
         rsp_valid_ff <= tag2_ff.vld && tag2_ff.last;
      end
      tag1_ff.first    <= tag_in.first;
      tag1_ff.last     <= tag_in.last;
      tag1_ff.lag      <= tag_in.lag;
      tag1_ff.last_lag <= tag_in.last_lag;
      tag2_ff.first    <= tag1_ff.first;
      tag2_ff.last     <= tag1_ff.last;
      tag2_ff.lag      <= tag1_ff.lag;
      tag2_ff.last_lag <= tag1_ff.last_lag;
      prod_ff <= $signed(a_data) * $signed(b_data);
   end

   // Sums wrap modulo the result width, which matches exact arithmetic at default sizes.
   assign prod_ext = EXT_BITS'(prod_ff);
   assign term = prod_ext[CORR_BITS-1:0];
   assign acc_in = tag2_ff.first ? term : acc_ff + term;

   always_ff @(posedge clock) begin
      if (tag2_ff.vld) begin
         acc_ff <= acc_in;
      end
      if (tag2_ff.vld && tag2_ff.last) begin
         corr_ff     <= acc_in;
         lag_ff      <= tag2_ff.lag;
         last_lag_ff <= tag2_ff.last_lag;
      end
   end

   // The last-lag mark is shown only together with its result.
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lag         = lag_ff;
   assign rsp_correlation = corr_ff;
   assign rsp_last_lag    = last_lag_ff && rsp_valid_ff;

endmodule

/* design/ccc_seq.sv */
// Sequencer: loads samples into memory and walks every (lag, position) pair.
module ccc_seq
   import ccc_pkg::*;
#(
   parameter int MAX_LENGTH = DEF_MAX_LENGTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [$clog2(MAX_LENGTH+1)-1:0] len,
   output logic                            busy,
   output logic                            wr_en,
   output logic [$clog2(MAX_LENGTH)-1:0]   wr_addr,
   output logic [$clog2(MAX_LENGTH)-1:0]   rd_addr_a,
   output logic [$clog2(MAX_LENGTH)-1:0]   rd_addr_b,
   output term_tag_type                    tag
);

   localparam int IDX_BITS = $clog2(MAX_LENGTH);
   localparam int CNT_BITS = $clog2(MAX_LENGTH + 1);

   seq_state_type        state_ff;
   seq_state_type        state_in;
   logic [IDX_BITS-1:0]  load_count_ff;
   logic [IDX_BITS-1:0]  load_count_in;
   logic [IDX_BITS-1:0]  i_ff;
   logic [IDX_BITS-1:0]  i_in;
   logic [IDX_BITS-1:0]  l_ff;
   logic [IDX_BITS-1:0]  l_in;
   logic [IDX_BITS-1:0]  k_ff;
   logic [IDX_BITS-1:0]  k_in;
   logic [1:0]           drain_ff;
   logic [1:0]           drain_in;
   logic [CNT_BITS-1:0]  len_m1;
   logic [CNT_BITS-1:0]  count_next;
   logic [CNT_BITS-1:0]  k_restart;
   logic                 l_last;
   logic                 i_last;
   logic                 k_wrap;

   assign len_m1     = len - CNT_BITS'(1);
   assign count_next = CNT_BITS'(load_count_ff) + CNT_BITS'(1);
   assign l_last     = (CNT_BITS'(l_ff) == len_m1);
   assign i_last     = (CNT_BITS'(i_ff) == len_m1);
   assign k_wrap     = (CNT_BITS'(k_ff) == len_m1);
   // Start of lag i+1 reads B at (L - (i+1)), which is never zero here.
   assign k_restart  = len_m1 - CNT_BITS'(i_ff);

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      i_in          = i_ff;
      l_in          = l_ff;
      k_in          = k_ff;
      drain_in      = drain_ff;
      busy          = 1'b1;
      wr_en         = 1'b0;
      tag.vld       = 1'b0;
      tag.first     = (l_ff == '0);
      tag.last      = l_last;
      tag.lag       = LAG_BITS'(i_ff);
      tag.last_lag  = i_last;
      unique case (state_ff)
         ST_LOAD: begin
            busy = 1'b0;
            if (start) begin
               wr_en = 1'b1;
               if (count_next >= len) begin
                  load_count_in = '0;
                  i_in          = '0;
                  l_in          = '0;
                  k_in          = '0;
                  state_in      = ST_RUN;
               end else begin
                  load_count_in = count_next[IDX_BITS-1:0];
               end
            end
         end
         ST_RUN: begin
            tag.vld = 1'b1;
            if (l_last) begin
               l_in = '0;
               if (i_last) begin
                  drain_in = '0;
                  state_in = ST_DRAIN;
               end else begin
                  i_in = i_ff + IDX_BITS'(1);
                  k_in = k_restart[IDX_BITS-1:0];
               end
            end else begin
               l_in = l_ff + IDX_BITS'(1);
               k_in = k_wrap ? '0 : k_ff + IDX_BITS'(1);
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_END) begin
               state_in = ST_LOAD;
            end else begin
               drain_in = drain_ff + 2'd1;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_LOAD;
         load_count_ff <= '0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
      end
      i_ff     <= i_in;
      l_ff     <= l_in;
      k_ff     <= k_in;
      drain_ff <= drain_in;
   end

   assign wr_addr   = load_count_ff;
   assign rd_addr_a = l_ff;
   assign rd_addr_b = k_ff;

   a_run_index_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN) |-> (CNT_BITS'(l_ff) < len) && (CNT_BITS'(k_ff) < len)
                               && (CNT_BITS'(i_ff) < len))
      else $error("correlation index outside the vector length");

endmodule

/* design/circular_cross_correlation.sv */
// Top level of the circular cross-correlation engine.
//
// Usage: each input transaction (start high while busy is low) carries one
// sample of vector A and the sample of vector B at the same position. The
// samples are written straight into two sample memories. When the number of
// loaded transactions reaches the effective vector length L (the
// vector_length register clamped to 2 .. MAX_LENGTH), busy rises and the
// block computes r[i] = sum over l of A[l] * B[(l + L - i) mod L] for every
// lag i, in ascending order. Each result is shown for exactly one cycle with
// rsp_valid high; rsp_last_lag marks lag L-1. The receiver cannot stall, so
// results are simply presented and taken.
// Timing: one shared multiplier does one product per cycle, fed by a read of
// both memories for each (lag, position) term; after the last term the
// pipeline drains, and busy falls in the cycle after the last result. New
// samples are accepted only while busy is low, so a new vector pair is loaded
// only after every lag of the previous one has been delivered.
// Reset clears the load count, the pipeline valid bits and restores
// vector_length to 40. Memory contents are not cleared. The register must be
// written only while the block is idle.
module circular_cross_correlation
   import ccc_pkg::*;
#(
   parameter int MAX_LENGTH  = DEF_MAX_LENGTH,
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // Input channel
   input  logic                     start,
   output logic                     busy,
   input  logic [SAMPLE_BITS-1:0]   req_sample_a,
   input  logic [SAMPLE_BITS-1:0]   req_sample_b,
   // Result channel
   output logic                     rsp_valid,
   output logic [LAG_BITS-1:0]      rsp_lag,
   output logic [CORR_BITS-1:0]     rsp_correlation,
   output logic                     rsp_last_lag,
   // Configuration port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   localparam int IDX_BITS = $clog2(MAX_LENGTH);
   localparam int CNT_BITS = $clog2(MAX_LENGTH + 1);

   logic [CNT_BITS-1:0]    len;
   logic                   wr_en;
   logic [IDX_BITS-1:0]    wr_addr;
   logic [IDX_BITS-1:0]    rd_addr_a;
   logic [IDX_BITS-1:0]    rd_addr_b;
   logic [SAMPLE_BITS-1:0] a_data;
   logic [SAMPLE_BITS-1:0] b_data;
   term_tag_type           tag;

   ccc_csr #(
      .MAX_LENGTH(MAX_LENGTH)
   ) u_csr (
      .clock  (clock),
      .reset  (reset),
      .psel   (psel),
      .penable(penable),
      .pwrite (pwrite),
      .paddr  (paddr),
      .pwdata (pwdata),
      .prdata (prdata),
      .pready (pready),
      .len    (len)
   );

   // The sequencer owns the load count and the lag/position counters.
   ccc_seq #(
      .MAX_LENGTH(MAX_LENGTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .len      (len),
      .busy     (busy),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .rd_addr_a(rd_addr_a),
      .rd_addr_b(rd_addr_b),
      .tag      (tag)
   );

   // Both memories are written at the load position; A is read at position l
   // and B at the rotated position in the same cycle.
   ccc_sample_ram #(
      .DEPTH(MAX_LENGTH),
      .WIDTH(SAMPLE_BITS)
   ) u_store_a (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_sample_a),
      .rd_addr(rd_addr_a),
      .rd_data(a_data)
   );

   ccc_sample_ram #(
      .DEPTH(MAX_LENGTH),
      .WIDTH(SAMPLE_BITS)
   ) u_store_b (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(req_sample_b),
      .rd_addr(rd_addr_b),
      .rd_data(b_data)
   );

   ccc_mac #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_mac (
      .clock          (clock),
      .reset          (reset),
      .tag_in         (tag),
      .a_data         (a_data),
      .b_data         (b_data),
      .rsp_valid      (rsp_valid),
      .rsp_lag        (rsp_lag),
      .rsp_correlation(rsp_correlation),
      .rsp_last_lag   (rsp_last_lag)
   );

   // Results appear only while a pair is being processed.
   a_result_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result transaction outside a busy period");

   a_last_is_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_lag |-> rsp_valid)
      else $error("last-lag mark without a result");

   // The block returns to loading only right after the final lag.
   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> $past(rsp_valid && rsp_last_lag))
      else $error("busy dropped before the final lag was delivered");

endmodule
